// File: rtl/core/ambient_backlight_brightness_macros.svh
`ifndef AMBIENT_BACKLIGHT_BRIGHTNESS_MACROS_SVH
`define AMBIENT_BACKLIGHT_BRIGHTNESS_MACROS_SVH

// same-cycle implication
`define ABB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ABB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/abb_pkg.sv
package abb_pkg;

   localparam int FILTER_FRAC_BITS = 8;

   localparam int MODE_W    = 2;
   localparam int SAMPLE_W  = 12;
   localparam int MANUAL_W  = 8;
   localparam int LEVEL_W   = 7;
   localparam int PWM_W     = 16;
   localparam int GAIN_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PWM_MAX = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN    = 1'd1;

   localparam logic [PWM_W-1:0]    PWM_MAX_RESET = 16'd999;
   localparam logic [GAIN_W-1:0]   GAIN_RESET    = 8'd26;
   localparam logic [LEVEL_W-1:0]  LEVEL_RESET   = 7'd50;

   localparam logic [SAMPLE_W-1:0] AMB_LO   = 12'd300;
   localparam logic [SAMPLE_W-1:0] AMB_HI   = 12'd3500;
   localparam logic [LEVEL_W-1:0]  PCT_LO   = 7'd10;
   localparam logic [LEVEL_W-1:0]  PCT_HI   = 7'd100;
   localparam logic [LEVEL_W-1:0]  SLEW_MAX = 7'd5;
   localparam logic [LEVEL_W-1:0]  PCT_SPAN = 7'd90;

   // x/25 as (x*RECIP)>>RECIP_SHIFT, exact for x below 2^21
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 27;
   localparam logic [RECIP_W-1:0] RECIP_25 = 23'd5368710;

   localparam int SMOOTH_W = SAMPLE_W + FILTER_FRAC_BITS;
   localparam int QUOT_IN_W = 21;
   localparam int MUL_A_W = (SMOOTH_W > QUOT_IN_W) ? SMOOTH_W : QUOT_IN_W;
   localparam int MUL_B_W = RECIP_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int STATE_W = 4;
   typedef logic [STATE_W-1:0] state_type;

   localparam state_type S_IDLE = 4'd0;
   localparam state_type S_FILT = 4'd1;
   localparam state_type S_FUPD = 4'd2;
   localparam state_type S_MAP1 = 4'd3;
   localparam state_type S_MAP2 = 4'd4;
   localparam state_type S_MAP3 = 4'd5;
   localparam state_type S_CMP1 = 4'd6;
   localparam state_type S_CMP2 = 4'd7;
   localparam state_type S_DONE = 4'd8;

endpackage

// File: rtl/core/abb_req_if.sv
interface abb_req_if;
   logic                          valid;
   logic                          ready;
   logic [abb_pkg::MODE_W-1:0]    mode;
   logic [abb_pkg::SAMPLE_W-1:0]  sample;
   logic                          sample_ok;
   logic [abb_pkg::MANUAL_W-1:0]  manual_percent;
   logic                          auto_request;

   modport source (
      output valid, mode, sample, sample_ok, manual_percent, auto_request,
      input  ready
   );
   modport sink (
      input  valid, mode, sample, sample_ok, manual_percent, auto_request,
      output ready
   );
endinterface

// File: rtl/core/abb_rsp_if.sv
interface abb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [abb_pkg::LEVEL_W-1:0]   brightness;
   logic [abb_pkg::PWM_W-1:0]     compare_value;
   logic                          auto_active;
   logic [abb_pkg::SAMPLE_W-1:0]  ambient_raw;

   modport source (
      output valid, brightness, compare_value, auto_active, ambient_raw,
      input  ready
   );
   modport sink (
      input  valid, brightness, compare_value, auto_active, ambient_raw,
      output ready
   );
endinterface

// File: rtl/core/ambient_backlight_brightness.sv
// Ambient-light backlight controller. Each accepted item gives one result with the
// brightness percent, the PWM compare value, the auto flag and the last raw sample.
// One shared multiplier under a small sequencer does the low-pass filter step, the
// light-to-percent mapping and the PWM scaling in turn, with divisions by constants
// done as reciprocal multiplies. An ambient tick in auto mode steps through S_FILT, S_FUPD
// (skipped with its multiply when the filter seeds), S_MAP1 to S_MAP3, S_CMP1, S_CMP2 and
// S_DONE; every other item steps through S_CMP1, S_CMP2 and S_DONE. A new item is taken
// only from S_IDLE, the cycle after the result is handed to the output register.
// The output register holds a result until it is taken.
`include "ambient_backlight_brightness_macros.svh"

module ambient_backlight_brightness (
   input  logic                            clock,
   input  logic                            reset,
   abb_req_if.sink                         req_ch,
   abb_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [abb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [abb_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import abb_pkg::*;

   state_type             state_ff, state_in;
   logic [PWM_W-1:0]      pwm_max_ff, pwm_max_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  auto_ff, auto_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [SMOOTH_W-1:0]   smooth_ff, smooth_in;
   logic [SAMPLE_W-1:0]   last_raw_ff, last_raw_in;
   logic [SAMPLE_W-1:0]   raw_ff, raw_in;
   logic                  up_ff, up_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]    bright_ff, bright_in;
   logic [PWM_W-1:0]      cmp_ff, cmp_in;
   logic                  auto_out_ff, auto_out_in;
   logic [SAMPLE_W-1:0]   raw_out_ff, raw_out_in;

   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic                  mul_go;
   logic [PROD_W-1:0]     mul_p;

   logic                  accept;
   logic [SAMPLE_W-1:0]   raw_sel;
   logic [SMOOTH_W-1:0]   r_val, diff, step;
   logic [SAMPLE_W-1:0]   v_int, v_clamp;
   logic [LEVEL_W:0]      target, lvl_up, lvl_dn;

   assign mul_p  = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.brightness    = bright_ff;
   assign rsp_ch.compare_value = cmp_ff;
   assign rsp_ch.auto_active   = auto_out_ff;
   assign rsp_ch.ambient_raw   = raw_out_ff;

   assign raw_sel = req_ch.sample_ok ? req_ch.sample : last_raw_ff;
   assign r_val   = {raw_ff, {FILTER_FRAC_BITS{1'b0}}};
   assign diff    = (r_val > smooth_ff) ? (r_val - smooth_ff) : (smooth_ff - r_val);
   assign step    = prod_ff[SMOOTH_W+7:8];
   assign v_int   = smooth_ff[SMOOTH_W-1:FILTER_FRAC_BITS];
   assign v_clamp = (v_int < AMB_LO) ? AMB_LO : ((v_int > AMB_HI) ? AMB_HI : v_int);
   assign target  = {1'b0, PCT_LO} + {1'b0, prod_ff[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT]};
   assign lvl_up  = {1'b0, level_ff} + {1'b0, SLEW_MAX};
   assign lvl_dn  = {1'b0, level_ff} - {1'b0, SLEW_MAX};

   always_comb begin
      state_in     = state_ff;
      pwm_max_in   = pwm_max_ff;
      gain_in      = gain_ff;
      auto_in      = auto_ff;
      level_in     = level_ff;
      smooth_in    = smooth_ff;
      last_raw_in  = last_raw_ff;
      raw_in       = raw_ff;
      up_in        = up_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      bright_in    = bright_ff;
      cmp_in       = cmp_ff;
      auto_out_in  = auto_out_ff;
      raw_out_in   = raw_out_ff;
      mul_a        = '0;
      mul_b        = '0;
      mul_go       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_PWM_MAX: pwm_max_in = csr_wdata;
            CSR_GAIN:    gain_in    = csr_wdata[GAIN_W-1:0];
            default:     ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP1;
               unique case (req_ch.mode)
                  MODE_TICK: begin
                     if (auto_ff) begin
                        last_raw_in = raw_sel;
                        raw_in      = raw_sel;
                        state_in    = S_FILT;
                     end
                  end
                  MODE_MANUAL: begin
                     auto_in  = 1'b0;
                     level_in = (req_ch.manual_percent > MANUAL_W'(PCT_HI)) ?
                                PCT_HI : req_ch.manual_percent[LEVEL_W-1:0];
                  end
                  MODE_AUTO: auto_in = req_ch.auto_request;
                  default:   ;
               endcase
            end
         end
         S_FILT: begin
            if (smooth_ff == '0) begin
               smooth_in = r_val;
               state_in  = S_MAP1;
            end else begin
               mul_go   = 1'b1;
               mul_a    = MUL_A_W'(diff);
               mul_b    = MUL_B_W'(gain_ff);
               up_in    = (r_val > smooth_ff);
               state_in = S_FUPD;
            end
         end
         S_FUPD: begin
            smooth_in = up_ff ? (smooth_ff + step) : (smooth_ff - step);
            state_in  = S_MAP1;
         end
         S_MAP1: begin
            mul_go   = 1'b1;
            mul_a    = MUL_A_W'(v_clamp - AMB_LO);
            mul_b    = MUL_B_W'(PCT_SPAN);
            state_in = S_MAP2;
         end
         S_MAP2: begin
            // divide by 3200 as shift by 7 then divide by 25
            mul_go   = 1'b1;
            mul_a    = MUL_A_W'(prod_ff[18:7]);
            mul_b    = RECIP_25;
            state_in = S_MAP3;
         end
         S_MAP3: begin
            priority if (target > lvl_up) begin
               level_in = lvl_up[LEVEL_W-1:0];
            end else if (target + {1'b0, SLEW_MAX} < {1'b0, level_ff}) begin
               level_in = lvl_dn[LEVEL_W-1:0];
            end else begin
               level_in = target[LEVEL_W-1:0];
            end
            if (level_in > PCT_HI) begin
               level_in = PCT_HI;
            end
            state_in = S_CMP1;
         end
         S_CMP1: begin
            mul_go   = 1'b1;
            mul_a    = MUL_A_W'(level_ff);
            mul_b    = MUL_B_W'(pwm_max_ff);
            state_in = S_CMP2;
         end
         S_CMP2: begin
            // divide by 100 as shift by 2 then divide by 25
            mul_go   = 1'b1;
            mul_a    = MUL_A_W'(prod_ff[QUOT_IN_W+1:2]);
            mul_b    = RECIP_25;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               bright_in    = level_ff;
               cmp_in       = prod_ff[RECIP_SHIFT+PWM_W-1:RECIP_SHIFT];
               auto_out_in  = auto_ff;
               raw_out_in   = last_raw_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (mul_go) begin
         prod_in = mul_p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pwm_max_ff   <= PWM_MAX_RESET;
         gain_ff      <= GAIN_RESET;
         auto_ff      <= 1'b1;
         level_ff     <= LEVEL_RESET;
         smooth_ff    <= '0;
         last_raw_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pwm_max_ff   <= pwm_max_in;
         gain_ff      <= gain_in;
         auto_ff      <= auto_in;
         level_ff     <= level_in;
         smooth_ff    <= smooth_in;
         last_raw_ff  <= last_raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      up_ff       <= up_in;
      prod_ff     <= prod_in;
      bright_ff   <= bright_in;
      cmp_ff      <= cmp_in;
      auto_out_ff <= auto_out_in;
      raw_out_ff  <= raw_out_in;
   end

   `ABB_ASSERT_NOW(a_level_range, clock, reset, 1'b1, level_ff <= PCT_HI, "level above 100")
   `ABB_ASSERT_NEXT(a_slew_limit, clock, reset, state_ff == S_MAP3, (level_ff <= $past(level_ff) + SLEW_MAX) && (level_ff + SLEW_MAX >= $past(level_ff)), "slew limit broken")
   `ABB_ASSERT_NEXT(a_hold_result, clock, reset, (state_ff == S_DONE) && rsp_valid_ff && !rsp_ch.ready, (state_ff == S_DONE) && $stable(bright_ff) && $stable(cmp_ff), "pending item overwritten")

endmodule

// File: sim/backlight_checker.sv
module backlight_checker (
   input  logic                           clock,
   input  logic                           reset,
   abb_req_if                             req_ch,
   abb_rsp_if                             rsp_ch,
   input  logic                           csr_we,
   input  logic [abb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abb_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import abb_pkg::*;

   typedef struct packed {
      logic [LEVEL_W-1:0]  brightness;
      logic [PWM_W-1:0]    compare_value;
      logic                auto_active;
      logic [SAMPLE_W-1:0] ambient_raw;
   } backlight_type;

   backlight_type backlight_due[$];
   int unsigned   fail_count = 0;
   int unsigned   due_count = 0;

   // shadow of the block state and its registers
   int unsigned pwm_top;
   int unsigned lp_gain;
   bit          auto_mode;
   int unsigned lvl_pct;
   int unsigned filtered;
   int unsigned held_raw;

   assign mismatches  = fail_count;
   assign outstanding = due_count;

   function automatic backlight_type predict_backlight(logic [MODE_W-1:0] mode,
         logic [SAMPLE_W-1:0] sample, logic sample_ok, logic [MANUAL_W-1:0] manual,
         logic auto_req);
      int unsigned   raw;
      int unsigned   scaled;
      int unsigned   light;
      int unsigned   goal;
      backlight_type res;
      case (mode)
         MODE_TICK: begin
            if (auto_mode) begin
               raw = sample_ok ? 32'(sample) : held_raw;
               scaled = raw << FILTER_FRAC_BITS;
               held_raw = raw;
               if (filtered == 0)
                  filtered = scaled;
               else if (scaled > filtered)
                  filtered = filtered + ((lp_gain * (scaled - filtered)) >> 8);
               else
                  filtered = filtered - ((lp_gain * (filtered - scaled)) >> 8);
               light = filtered >> FILTER_FRAC_BITS;
               if (light < 32'(AMB_LO)) light = 32'(AMB_LO);
               if (light > 32'(AMB_HI)) light = 32'(AMB_HI);
               goal = 32'(PCT_LO) + (light - 32'(AMB_LO)) * 32'(PCT_SPAN)
                      / (32'(AMB_HI) - 32'(AMB_LO));
               if (goal > lvl_pct + 32'(SLEW_MAX)) goal = lvl_pct + 32'(SLEW_MAX);
               if (goal + 32'(SLEW_MAX) < lvl_pct) goal = lvl_pct - 32'(SLEW_MAX);
               if (goal > 32'(PCT_HI)) goal = 32'(PCT_HI);
               lvl_pct = goal;
            end
         end
         MODE_MANUAL: begin
            auto_mode = 1'b0;
            lvl_pct = (manual > MANUAL_W'(PCT_HI)) ? 32'(PCT_HI) : 32'(manual);
         end
         MODE_AUTO: begin
            auto_mode = auto_req;
         end
         default: begin
         end
      endcase
      res.brightness    = LEVEL_W'(lvl_pct);
      res.compare_value = PWM_W'(lvl_pct * pwm_top / 32'(PCT_HI));
      res.auto_active   = auto_mode;
      res.ambient_raw   = SAMPLE_W'(held_raw);
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      backlight_type want;
      if (reset) begin
         pwm_top   = 32'(PWM_MAX_RESET);
         lp_gain   = 32'(GAIN_RESET);
         auto_mode = 1'b1;
         lvl_pct   = 32'(LEVEL_RESET);
         filtered  = 0;
         held_raw  = 0;
         backlight_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PWM_MAX: pwm_top = 32'(csr_wdata[PWM_W-1:0]);
               CSR_GAIN:    lp_gain = 32'(csr_wdata[GAIN_W-1:0]);
               default: begin
               end
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (backlight_due.size() == 0) begin
               fail_count++;
               $display("%0t: result with no item pending, brightness %0d compare %0d",
                        $time, rsp_ch.brightness, rsp_ch.compare_value);
            end else begin
               want = backlight_due.pop_front();
               check_field("brightness", 32'(want.brightness), 32'(rsp_ch.brightness));
               check_field("compare_value", 32'(want.compare_value),
                           32'(rsp_ch.compare_value));
               check_field("auto_active", 32'(want.auto_active), 32'(rsp_ch.auto_active));
               check_field("ambient_raw", 32'(want.ambient_raw), 32'(rsp_ch.ambient_raw));
            end
         end
         if (req_ch.valid && req_ch.ready)
            backlight_due.push_back(predict_backlight(req_ch.mode, req_ch.sample,
               req_ch.sample_ok, req_ch.manual_percent, req_ch.auto_request));
      end
      due_count = backlight_due.size();
   end

endmodule

// File: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import abb_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PHASES = 6;
   localparam int unsigned ITEMS_PER_PHASE = 300;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;
   int unsigned          mismatches;
   int unsigned          outstanding;
   int unsigned          cycles = 0;
   int unsigned          rsp_hold = 0;
   bit                   req_gaps;
   bit                   rsp_stalls;
   int unsigned          ambient_base;

   abb_req_if req_ch();
   abb_rsp_if rsp_ch();

   ambient_backlight_brightness i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   backlight_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (rsp_stalls && $urandom_range(0, 2) == 0) rsp_hold <= gap_len();
      end
   end

   task automatic send_item(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] sample,
         logic sample_ok, logic [MANUAL_W-1:0] manual, logic auto_req);
      int unsigned gap;
      req_ch.valid          <= 1'b1;
      req_ch.mode           <= mode;
      req_ch.sample         <= sample;
      req_ch.sample_ok      <= sample_ok;
      req_ch.manual_percent <= manual;
      req_ch.auto_request   <= auto_req;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      gap = req_gaps ? gap_len() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_regs(logic [CSR_DAT_W-1:0] pwm, logic [CSR_DAT_W-1:0] gain);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_PWM_MAX;
      csr_wdata <= pwm;
      @(negedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= gain;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_item(output logic [MODE_W-1:0] mode,
         output logic [SAMPLE_W-1:0] sample, output logic sample_ok,
         output logic [MANUAL_W-1:0] manual, output logic auto_req);
      int unsigned r;
      int signed   s;
      r = $urandom_range(0, 99);
      if (r < 80) mode = MODE_TICK;
      else if (r < 85) mode = MODE_MANUAL;
      else if (r < 97) mode = MODE_AUTO;
      else mode = MODE_UNUSED;
      // ambient light drifts around a base level that jumps now and then
      if ($urandom_range(0, 19) == 0) ambient_base = $urandom_range(0, 4095);
      r = $urandom_range(0, 99);
      if (r < 70) begin
         s = int'(ambient_base) + int'($urandom_range(0, 64)) - 32;
         if (s < 0) s = 0;
         if (s > 4095) s = 4095;
         sample = SAMPLE_W'(s);
      end else if (r < 74) begin
         sample = '0;
      end else if (r < 78) begin
         sample = '1;
      end else begin
         sample = SAMPLE_W'($urandom_range(0, 4095));
      end
      sample_ok = ($urandom_range(0, 9) != 0);
      manual    = ($urandom_range(0, 3) == 0) ? MANUAL_W'($urandom_range(101, 255))
                                             : MANUAL_W'($urandom_range(0, 100));
      auto_req  = (mode == MODE_AUTO) ? ($urandom_range(0, 4) != 0) : 1'($urandom);
   endtask

   initial begin
      logic [CSR_DAT_W-1:0] pwm_set[PHASES];
      logic [CSR_DAT_W-1:0] gain_set[PHASES];
      logic [MODE_W-1:0]    mode;
      logic [SAMPLE_W-1:0]  sample;
      logic                 sample_ok;
      logic [MANUAL_W-1:0]  manual;
      logic                 auto_req;
      int unsigned          counted;

      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_PWM_MAX;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.mode           = MODE_TICK;
      req_ch.sample         = '0;
      req_ch.sample_ok      = 1'b0;
      req_ch.manual_percent = '0;
      req_ch.auto_request   = 1'b0;
      req_gaps              = 1'b0;
      rsp_stalls            = 1'b0;
      ambient_base          = 2000;

      pwm_set[0] = CSR_DAT_W'(PWM_MAX_RESET);
      gain_set[0] = CSR_DAT_W'(GAIN_RESET);
      pwm_set[1] = 16'd65535;                gain_set[1] = 16'd255;
      pwm_set[2] = 16'd1;                    gain_set[2] = 16'd1;
      pwm_set[3] = 16'd0;                    gain_set[3] = 16'd0;
      pwm_set[4] = CSR_DAT_W'($urandom_range(0, 65535));
      gain_set[4] = CSR_DAT_W'($urandom_range(0, 65535));
      pwm_set[5] = CSR_DAT_W'(PWM_MAX_RESET);
      gain_set[5] = CSR_DAT_W'(GAIN_RESET);

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items from the reset state
      req_gaps   = 1'($urandom);
      rsp_stalls = 1'($urandom);
      send_item(MODE_TICK, 12'd0, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd4095, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd0, 1'b1, 8'd255, 1'b1);
      send_item(MODE_TICK, 12'd2222, 1'b0, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd3500, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd3000, 1'b0, 8'd0, 1'b0);
      send_item(MODE_MANUAL, 12'd0, 1'b0, 8'd255, 1'b0);
      send_item(MODE_TICK, 12'd123, 1'b1, 8'd0, 1'b1);
      send_item(MODE_MANUAL, 12'd0, 1'b0, 8'd101, 1'b0);
      send_item(MODE_MANUAL, 12'd0, 1'b0, 8'd100, 1'b0);
      send_item(MODE_MANUAL, 12'd4095, 1'b1, 8'd0, 1'b1);
      send_item(MODE_AUTO, 12'd0, 1'b0, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd4000, 1'b1, 8'd0, 1'b0);
      send_item(MODE_AUTO, 12'd0, 1'b0, 8'd0, 1'b1);
      send_item(MODE_TICK, 12'd4095, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd4095, 1'b1, 8'd0, 1'b0);
      send_item(MODE_UNUSED, 12'd4095, 1'b1, 8'd255, 1'b1);
      send_item(MODE_TICK, 12'd300, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd299, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd3501, 1'b1, 8'd0, 1'b0);
      send_item(MODE_TICK, 12'd0, 1'b0, 8'd0, 1'b0);
      send_item(MODE_MANUAL, 12'd0, 1'b0, 8'd50, 1'b0);
      send_item(MODE_AUTO, 12'd0, 1'b0, 8'd0, 1'b1);
      send_item(MODE_TICK, 12'd0, 1'b1, 8'd0, 1'b0);

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) write_regs(pwm_set[phase], gain_set[phase]);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if (counted % 40 == 0) begin
               req_gaps   = ($urandom_range(0, 3) != 0);
               rsp_stalls = ($urandom_range(0, 3) != 0);
            end
            random_item(mode, sample, sample_ok, manual, auto_req);
            counted++;
            send_item(mode, sample, sample_ok, manual, auto_req);
         end
      end

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
